/* sv/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache.
// Holds the request and response item layouts and the controller commands.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 16;
   localparam int CAP_BITS   = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_rd;
      logic commit;
      logic upd_rd;
      logic respond;
   } ctl_cmd_type;

endpackage

/* sv/lkvc_ctrl.sv */
// ----------------------------------------------------------------------------
// lkvc_ctrl: sequencer of the LRU key-value cache.
// Steps one item through a lookup sweep, a commit and a rank-update sweep.
// ----------------------------------------------------------------------------
module lkvc_ctrl #(
   parameter int ENTRIES = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] addr,
   output lkvc_pkg::ctl_cmd_type                       cmd
);
   import lkvc_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_COMMIT,
      ST_UPDATE,
      ST_UPD_END,
      ST_RESPOND
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          busy_ff, busy_in;
   logic          take;

   assign take = start && ((state_ff == ST_IDLE) || (state_ff == ST_RESPOND));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE, ST_RESPOND: begin
            if (take) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCAN_END;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_UPDATE;
            idx_in   = '0;
         end
         ST_UPDATE: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_UPD_END;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_UPD_END: begin
            state_in = ST_RESPOND;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE) && (state_in != ST_RESPOND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign addr = idx_ff;

   always_comb begin
      cmd         = '0;
      cmd.load    = take;
      cmd.scan_rd = (state_ff == ST_SCAN);
      cmd.commit  = (state_ff == ST_COMMIT);
      cmd.upd_rd  = (state_ff == ST_UPDATE);
      cmd.respond = (state_ff == ST_RESPOND);
   end

endmodule

/* sv/lkvc_datapath.sv */
// ----------------------------------------------------------------------------
// lkvc_datapath: entry storage, lookup tracking and recency ranks.
// Key, value and rank live in memories; valid bits and the count in flops.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] addr,
   input  lkvc_pkg::ctl_cmd_type                       cmd,
   input  lkvc_pkg::req_type                           req_data,
   input  logic                                        csr_valid,
   input  logic [lkvc_pkg::CAP_BITS-1:0]               csr_data,
   output lkvc_pkg::rsp_type                           rsp_data
);
   import lkvc_pkg::*;

   localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW    = AW;
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CW > CAP_BITS) ? CW : CAP_BITS;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_HIT,
      MODE_INSERT
   } upd_mode_type;

   // Storage.
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [RW-1:0]         rank_mem  [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [CW-1:0]         count_ff;
   logic [CAP_BITS-1:0]   capacity_ff;

   // Registered read data and the address it belongs to.
   logic [KEY_BITS-1:0]   key_q_ff;
   logic [VALUE_BITS-1:0] value_q_ff;
   logic [RW-1:0]         rank_q_ff;
   logic [AW-1:0]         addr_d_ff;
   logic                  scan_pend_ff;
   logic                  upd_pend_ff;

   // Lookup trackers.
   req_type               req_ff;
   logic                  found_ff;
   logic [AW-1:0]         found_idx_ff;
   logic [RW-1:0]         found_rank_ff;
   logic [VALUE_BITS-1:0] found_value_ff;
   logic                  free_seen_ff;
   logic [AW-1:0]         free_idx_ff;
   logic                  lru_seen_ff;
   logic [AW-1:0]         lru_idx_ff;
   logic [RW-1:0]         lru_rank_ff;
   logic [KEY_BITS-1:0]   lru_key_ff;

   // Rank update control.
   upd_mode_type          mode_ff, mode_in;
   logic [AW-1:0]         target_ff, target_in;
   logic [RW-1:0]         target_rank_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  rd_valid;
   logic                  rd_match;
   logic                  is_put;
   logic [CMP_W-1:0]      cap_lo;
   logic [CMP_W-1:0]      cap_eff;
   logic                  can_fill;
   logic                  insert;
   logic [RW-1:0]         rank_new;

   assign rd_valid = valid_ff[addr_d_ff];
   assign rd_match = rd_valid && (key_q_ff == req_ff.key);
   assign is_put   = (req_ff.action == ACT_PUT);

   // A capacity of zero acts as one, any larger than the entry count as that count.
   assign cap_lo   = (capacity_ff == '0) ? CMP_W'(1) : CMP_W'(capacity_ff);
   assign cap_eff  = (cap_lo > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_lo;
   assign can_fill = CMP_W'(count_ff) < cap_eff;
   assign insert   = is_put && !found_ff;

   always_comb begin
      mode_in   = MODE_NONE;
      target_in = found_idx_ff;
      if (found_ff) begin
         mode_in = MODE_HIT;
      end else if (is_put) begin
         mode_in   = MODE_INSERT;
         target_in = can_fill ? free_idx_ff : lru_idx_ff;
      end
      rsp_in.hit         = found_ff;
      rsp_in.read_value  = (found_ff && !is_put) ? found_value_ff : '0;
      rsp_in.evicted     = insert && !can_fill;
      rsp_in.evicted_key = (insert && !can_fill) ? lru_key_ff : '0;
   end

   always_comb begin
      rank_new = rank_q_ff;
      case (mode_ff)
         MODE_HIT: begin
            if (addr_d_ff == target_ff) begin
               rank_new = '0;
            end else if (rd_valid && (rank_q_ff < target_rank_ff)) begin
               rank_new = rank_q_ff + RW'(1);
            end
         end
         MODE_INSERT: begin
            if (addr_d_ff == target_ff) begin
               rank_new = '0;
            end else if (rd_valid) begin
               rank_new = rank_q_ff + RW'(1);
            end
         end
         default: begin
            rank_new = rank_q_ff;
         end
      endcase
   end

   // Memories and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         key_q_ff   <= key_mem[addr];
         value_q_ff <= value_mem[addr];
      end
      if (cmd.scan_rd || cmd.upd_rd) begin
         rank_q_ff <= rank_mem[addr];
      end
      addr_d_ff <= addr;
      if (cmd.commit && insert) begin
         key_mem[target_in] <= req_ff.key;
      end
      if (cmd.commit && is_put) begin
         value_mem[target_in] <= req_ff.value;
      end
      if (upd_pend_ff) begin
         rank_mem[addr_d_ff] <= rank_new;
      end
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (scan_pend_ff) begin
         if (rd_match && !found_ff) begin
            found_idx_ff   <= addr_d_ff;
            found_rank_ff  <= rank_q_ff;
            found_value_ff <= value_q_ff;
         end
         if (!rd_valid && !free_seen_ff) begin
            free_idx_ff <= addr_d_ff;
         end
         if (rd_valid && (!lru_seen_ff || (rank_q_ff >= lru_rank_ff))) begin
            lru_idx_ff  <= addr_d_ff;
            lru_rank_ff <= rank_q_ff;
            lru_key_ff  <= key_q_ff;
         end
      end
      if (cmd.commit) begin
         target_ff      <= target_in;
         target_rank_ff <= found_rank_ff;
         rsp_ff         <= rsp_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         scan_pend_ff <= 1'b0;
         upd_pend_ff  <= 1'b0;
         found_ff     <= 1'b0;
         free_seen_ff <= 1'b0;
         lru_seen_ff  <= 1'b0;
         mode_ff      <= MODE_NONE;
      end else begin
         scan_pend_ff <= cmd.scan_rd;
         upd_pend_ff  <= cmd.upd_rd;
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (cmd.load) begin
            found_ff     <= 1'b0;
            free_seen_ff <= 1'b0;
            lru_seen_ff  <= 1'b0;
         end else if (scan_pend_ff) begin
            if (rd_match) begin
               found_ff <= 1'b1;
            end
            if (!rd_valid) begin
               free_seen_ff <= 1'b1;
            end
            if (rd_valid) begin
               lru_seen_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            mode_ff <= mode_in;
            if (insert) begin
               valid_ff[target_in] <= 1'b1;
               if (can_fill) begin
                  count_ff <= count_ff + CW'(1);
               end
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* sv/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement.
// Once start is taken, a lookup sweep, the commit and an update sweep run
// before the result strobe; the next start is taken at the earliest in
// the cycle that shows the result. Both sweeps run over the entry memories
// through one read port, one entry per cycle. The receiver cannot stall.
// Reset (synchronous) empties the store and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lkvc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output lkvc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_data
);
   import lkvc_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Each item makes two passes over the entries. The lookup pass reads
   // every entry and records the first key match, the first free slot and
   // the least recent valid entry. The commit cycle then writes key, value
   // and valid bit and registers the result. The update pass rewrites every
   // rank: on a hit, entries more recent than the hit entry age by one; on
   // an insert, every other valid entry ages by one; the touched entry gets
   // rank zero. A get that misses leaves the ranks as they are.

   ctl_cmd_type   cmd;
   logic [AW-1:0] addr;

   lkvc_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .addr  (addr),
      .cmd   (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .addr      (addr),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   // The result registers hold from the commit cycle; the strobe marks the
   // single cycle in which the item is delivered.
   assign rsp_valid = cmd.respond;

   // The capacity register takes a write in any cycle.
   assign csr_ready = 1'b1;

endmodule

/* sv/lkvc_checker.sv */
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks of the LRU key-value cache.
// Bound to the top level; watches the command handshake and the results.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input lkvc_pkg::rsp_type rsp_data
);
   import lkvc_pkg::*;

   // A result is shown only once the block can take the next item.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A taken item occupies the block and gives no result in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("item taken without going busy");

   // Every result is a single-cycle strobe.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // Eviction only on a miss, and a read value only from a hit without eviction.
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_data.evicted && rsp_data.hit) &&
                     ((rsp_data.read_value == '0) ||
                      (rsp_data.hit && !rsp_data.evicted)) &&
                     (rsp_data.evicted || (rsp_data.evicted_key == '0))))
      else $error("inconsistent result fields");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

/* verif/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache.
// A short table of directed accesses and capacity writes comes first. Random
// gets and puts follow, drawn mostly from a small key pool so that hits and
// evictions are frequent, over several capacity settings. A shadow copy of the
// cache predicts each result not typed in by hand; all are checked in order.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int ENTRIES      = 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 103;
   localparam int MAX_REPORTS  = 30;

   // One row of the directed table: either a capacity write or one access.
   // When known is set, want holds the result typed in by hand.
   typedef struct packed {
      logic                is_cfg;
      logic [CAP_BITS-1:0] cap;
      req_type             item;
      logic                known;
      rsp_type             want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_BITS-1:0] csr_data = '0;

   // Shadow copy of the cache contents, updated as each item is accepted.
   logic                  mirror_valid [ENTRIES];
   logic [KEY_BITS-1:0]   mirror_key   [ENTRIES];
   logic [VALUE_BITS-1:0] mirror_value [ENTRIES];
   int unsigned           mirror_rank  [ENTRIES];
   int unsigned           mirror_count;
   logic [CAP_BITS-1:0]   mirror_capacity;

   // Results that are owed by the cache, oldest first.
   rsp_type awaited_rsp [$];

   plan_row_type          directed_plan [$];
   logic [KEY_BITS-1:0]   key_pool [$];

   int error_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int hits_seen      = 0;
   int evictions_seen = 0;
   int cap_writes     = 0;
   int quiet_cycles   = 0;

   lru_key_value_cache #(
      .ENTRIES(ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic plan_row_type cfg_row(input logic [CAP_BITS-1:0] cap);
      plan_row_type r;
      r        = '0;
      r.is_cfg = 1'b1;
      r.cap    = cap;
      return r;
   endfunction

   function automatic plan_row_type access_row(input logic action,
                                               input logic [KEY_BITS-1:0] key,
                                               input logic [VALUE_BITS-1:0] value);
      plan_row_type r;
      r      = '0;
      r.item = {action, key, value};
      return r;
   endfunction

   function automatic plan_row_type checked_row(input logic action,
                                                input logic [KEY_BITS-1:0] key,
                                                input logic [VALUE_BITS-1:0] value,
                                                input logic hit,
                                                input logic [VALUE_BITS-1:0] read_value,
                                                input logic evicted,
                                                input logic [KEY_BITS-1:0] evicted_key);
      plan_row_type r;
      r       = access_row(action, key, value);
      r.known = 1'b1;
      r.want  = {hit, read_value, evicted, evicted_key};
      return r;
   endfunction

   // Applies one access to the shadow cache and returns the result it owes.
   // Ranks count up from 0 for the most recent entry. A lowered capacity does
   // not shrink the store; each new key then just replaces the oldest entry.
   function automatic rsp_type lru_access(input req_type item);
      rsp_type     r;
      int          found;
      int          slot;
      int unsigned worst;
      int unsigned limit;
      r     = '0;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && mirror_valid[i] && mirror_key[i] == item.key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         r.hit = 1'b1;
         if (item.action == ACT_PUT) begin
            mirror_value[found] = item.value;
         end else begin
            r.read_value = mirror_value[found];
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (mirror_valid[i] && i != found && mirror_rank[i] < mirror_rank[found]) begin
               mirror_rank[i]++;
            end
         end
         mirror_rank[found] = 0;
      end else if (item.action == ACT_PUT) begin
         if (mirror_capacity == 0) begin
            limit = 1;
         end else if (int'(mirror_capacity) > ENTRIES) begin
            limit = ENTRIES;
         end else begin
            limit = 32'(mirror_capacity);
         end
         slot = -1;
         if (mirror_count < limit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !mirror_valid[i]) begin
                  slot = i;
               end
            end
         end
         if (slot < 0) begin
            // Full: the entry with the highest rank goes.
            worst = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (mirror_valid[i] && (slot < 0 || mirror_rank[i] >= worst)) begin
                  slot  = i;
                  worst = mirror_rank[i];
               end
            end
            if (slot >= 0) begin
               r.evicted          = 1'b1;
               r.evicted_key      = mirror_key[slot];
               mirror_valid[slot] = 1'b0;
            end else begin
               slot = 0;
            end
         end else begin
            mirror_count++;
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (mirror_valid[i]) begin
               mirror_rank[i]++;
            end
         end
         mirror_valid[slot] = 1'b1;
         mirror_key[slot]   = item.key;
         mirror_value[slot] = item.value;
         mirror_rank[slot]  = 0;
         if (!r.evicted && mirror_count > ENTRIES) begin
            mirror_count = ENTRIES;
         end
      end
      return r;
   endfunction

   // Presents one item from the falling edge on and holds it until a rising
   // edge sees busy low. The shadow cache is updated at that same edge, so
   // predictions follow the order in which the cache takes the items.
   task automatic issue_item(input req_type item, input logic known,
                             input rsp_type typed_want);
      logic    taken;
      rsp_type want;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      want = lru_access(item);
      awaited_rsp.push_back(known ? typed_want : want);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Lowers start and waits until every owed result is in and the cache is
   // no longer busy, so that a capacity write lands on an idle block.
   task automatic settle();
      pause_sender(1);
      while (awaited_rsp.size() != 0 || busy) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      logic taken;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = csr_ready;
      end
      mirror_capacity = cap;
      cap_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Most gaps are short; a few are long enough for the next start to land
   // well after the cache has gone idle.
   function automatic int pick_gap(input logic burst);
      int roll;
      if (burst) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(0, 2);
      end else if (roll < 90) begin
         return $urandom_range(3, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   // Each result is shown for one cycle only and is taken at the rising edge
   // that ends that cycle.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (awaited_rsp.size() == 0) begin
            log_error($sformatf("result %0d arrived with nothing owed", results_seen));
         end else begin
            want = awaited_rsp.pop_front();
            hits_seen      += int'(want.hit);
            evictions_seen += int'(want.evicted);
            if (rsp_data.hit !== want.hit) begin
               log_error($sformatf("result %0d hit: got %b, want %b",
                                   results_seen, rsp_data.hit, want.hit));
            end
            if (rsp_data.read_value !== want.read_value) begin
               log_error($sformatf("result %0d read_value: got %h, want %h",
                                   results_seen, rsp_data.read_value, want.read_value));
            end
            if (rsp_data.evicted !== want.evicted) begin
               log_error($sformatf("result %0d evicted: got %b, want %b",
                                   results_seen, rsp_data.evicted, want.evicted));
            end
            if (rsp_data.evicted_key !== want.evicted_key) begin
               log_error($sformatf("result %0d evicted_key: got %h, want %h",
                                   results_seen, rsp_data.evicted_key, want.evicted_key));
            end
         end
      end
   end

   // Ends a hung run: any cycle with no handshake on any channel counts.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Stalled for %0d cycles with %0d results owed.",
                  quiet_cycles, awaited_rsp.size());
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CAP_BITS-1:0] phase_caps [9];
      plan_row_type        row;
      req_type             item;
      logic                burst;
      int                  pool_size;

      for (int i = 0; i < ENTRIES; i++) begin
         mirror_valid[i] = 1'b0;
         mirror_key[i]   = '0;
         mirror_value[i] = '0;
         mirror_rank[i]  = 0;
      end
      mirror_count    = 0;
      mirror_capacity = CAP_RESET;

      // Capacity 2 makes the eviction order easy to read off by hand.
      directed_plan.push_back(cfg_row(5'd2));
      directed_plan.push_back(checked_row(ACT_GET, 16'h0000, 16'h0000, 0, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_PUT, 16'h0000, 16'hFFFF, 0, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_GET, 16'h0000, 16'h0000, 1, 16'hFFFF, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_PUT, 16'hFFFF, 16'h0000, 0, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_GET, 16'hFFFF, 16'hFFFF, 1, 16'h0000, 0, 16'h0000));
      // A put to a present key overwrites it and reads back zero.
      directed_plan.push_back(checked_row(ACT_PUT, 16'hFFFF, 16'h1234, 1, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_PUT, 16'h5A5A, 16'hA5A5, 0, 16'h0000, 1, 16'h0000));
      directed_plan.push_back(checked_row(ACT_GET, 16'h0000, 16'h0000, 0, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_GET, 16'hFFFF, 16'h0000, 1, 16'h1234, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_PUT, 16'h8001, 16'h7FFE, 0, 16'h0000, 1, 16'h5A5A));
      directed_plan.push_back(checked_row(ACT_GET, 16'h5A5A, 16'h0000, 0, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(checked_row(ACT_GET, 16'h8001, 16'h0000, 1, 16'h7FFE, 0, 16'h0000));
      // A zero capacity acts as one, below the two entries already held.
      directed_plan.push_back(cfg_row(5'd0));
      directed_plan.push_back(checked_row(ACT_PUT, 16'h1111, 16'h0001, 0, 16'h0000, 1, 16'hFFFF));
      directed_plan.push_back(checked_row(ACT_PUT, 16'h2222, 16'h0002, 0, 16'h0000, 1, 16'h8001));
      directed_plan.push_back(access_row(ACT_GET, 16'h1111, 16'h0000));
      // An oversized capacity acts as the full entry count.
      directed_plan.push_back(cfg_row(5'd31));
      directed_plan.push_back(checked_row(ACT_PUT, 16'h3333, 16'hFFFF, 0, 16'h0000, 0, 16'h0000));
      directed_plan.push_back(access_row(ACT_PUT, 16'h0000, 16'h0000));
      directed_plan.push_back(access_row(ACT_GET, 16'h2222, 16'h0000));
      directed_plan.push_back(cfg_row(5'd16));
      directed_plan.push_back(access_row(ACT_PUT, 16'hAAAA, 16'h5555));
      directed_plan.push_back(access_row(ACT_GET, 16'h3333, 16'h0000));
      directed_plan.push_back(access_row(ACT_PUT, 16'h5555, 16'hAAAA));
      directed_plan.push_back(cfg_row(5'd1));
      directed_plan.push_back(access_row(ACT_PUT, 16'h7777, 16'h8888));
      directed_plan.push_back(access_row(ACT_GET, 16'h7777, 16'h0000));

      // Full size first, then a drop to 3 so the lowered capacity meets a
      // crowded store, then out-of-range codes, in-range sizes and a random size.
      phase_caps[0] = 5'd16;
      phase_caps[1] = 5'd3;
      phase_caps[2] = 5'd31;
      phase_caps[3] = 5'd1;
      phase_caps[4] = 5'd8;
      phase_caps[5] = 5'd0;
      phase_caps[6] = 5'd17;
      phase_caps[7] = CAP_BITS'($urandom_range(1, ENTRIES));
      phase_caps[8] = 5'd12;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < directed_plan.size(); r++) begin
         row = directed_plan[r];
         if (row.is_cfg) begin
            settle();
            write_capacity(row.cap);
         end else begin
            issue_item(row.item, row.known, row.want);
            pause_sender(pick_gap(1'b0));
         end
      end

      for (int p = 0; p < 9; p++) begin
         settle();
         write_capacity(phase_caps[p]);
         // A pool a little larger than the capacity keeps hits, misses and
         // evictions all common.
         pool_size = (phase_caps[p] == 0) ? 1 :
                     (int'(phase_caps[p]) > ENTRIES) ? ENTRIES : int'(phase_caps[p]);
         pool_size += $urandom_range(1, 4);
         key_pool.delete();
         repeat (pool_size) key_pool.push_back(KEY_BITS'($urandom));
         burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item.action = $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
            item.value  = VALUE_BITS'($urandom);
            if ($urandom_range(0, 99) < 88) begin
               item.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else begin
               item.key = KEY_BITS'($urandom);
            end
            issue_item(item, 1'b0, '0);
            if ($urandom_range(0, 39) == 0) begin
               // Let the cache drain completely before going on.
               settle();
            end else begin
               pause_sender(pick_gap(burst));
            end
         end
      end

      settle();
      repeat (2 * ENTRIES + 8) @(posedge clock);

      $display("Sent %0d items over %0d capacity writes; checked %0d results.",
               items_sent, cap_writes, results_seen);
      $display("Results included %0d hits and %0d evictions.", hits_seen, evictions_seen);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
sv/lkvc_pkg.sv
sv/lkvc_ctrl.sv
sv/lkvc_datapath.sv
sv/lru_key_value_cache.sv
sv/lkvc_checker.sv
verif/lru_key_value_cache_tb.sv
